// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// ===== hw/rtl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Types, constants and helpers of the segment allocator with compaction.
// ----------------------------------------------------------------------------
package sac_pkg;

  // Table geometry
  localparam int unsigned MaxSegments = 16;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);

  // Field widths
  localparam int unsigned KeyW  = 4;
  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 16;
  localparam int unsigned UsedW = 17;

  // Reset value of the address space size
  localparam logic [AddrW-1:0] MemSizeReset = 16'd1024;

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoSpace  = 3'd1,
    StNotFound = 3'd2,
    StInUse    = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SDecide,
    SShift,
    SFreeDone,
    SCompact,
    SAppend
  } state_e;

  typedef struct packed {
    cmd_e            command;
    logic [LenW-1:0] segment_length;
    logic [KeyW-1:0] segment_key;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic             is_relocation;
    logic [KeyW-1:0]  result_key;
    logic [AddrW-1:0] base_address;
    logic [LenW-1:0]  space_left;
    logic             last;
  } result_t;

  // One table row as stored in the RAM
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  length;
  } slot_t;

  // Result handed from the engine to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

  // Free units, saturating at zero when the space was shrunk below use
  function automatic logic [LenW-1:0] units_free(logic [UsedW-1:0] used,
                                                 logic [AddrW-1:0] space_units);
    logic [UsedW-1:0] mem_ext;
    logic [UsedW-1:0] diff;
    mem_ext = {1'b0, space_units};
    diff    = mem_ext - used;
    return (used >= mem_ext) ? '0 : diff[LenW-1:0];
  endfunction

endpackage

// ===== hw/rtl/sac_ram.sv =====
// ----------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sac_engine.sv =====
// ----------------------------------------------------------------------------
// sac_engine
// Sequencer that walks the segment table in RAM: key search, close-up on
// free, compaction and append on allocate.
// ----------------------------------------------------------------------------
module sac_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  sac_pkg::item_t            item_i,
  input  logic [sac_pkg::AddrW-1:0] memory_size_i,
  output logic                      busy_o,
  output sac_pkg::emit_t            emit_o
);

  sac_pkg::state_e              state_q, state_d;
  sac_pkg::item_t               item_q, item_d;
  logic [sac_pkg::CntW-1:0]     count_q, count_d;
  logic [sac_pkg::UsedW-1:0]    units_q, units_d;
  logic [sac_pkg::IdxW-1:0]     ptr_q, ptr_d;
  logic [sac_pkg::IdxW-1:0]     pos_q, pos_d;
  logic                         found_q, found_d;
  logic [sac_pkg::LenW-1:0]     flen_q, flen_d;
  logic [sac_pkg::UsedW-1:0]    top_q, top_d;
  logic [sac_pkg::UsedW-1:0]    next_q, next_d;

  // RAM access
  logic                         ram_we;
  logic [sac_pkg::IdxW-1:0]     ram_waddr;
  sac_pkg::slot_t               ram_wdata;
  logic [sac_pkg::IdxW-1:0]     ram_raddr;
  sac_pkg::slot_t               ram_rdata;

  // Shared conditions
  logic [sac_pkg::IdxW-1:0]     last_idx;
  logic [sac_pkg::IdxW-1:0]     ptr_inc;
  logic                         at_last;
  logic                         shift_last;
  logic                         pos_last;
  logic                         key_hit;
  logic [sac_pkg::LenW-1:0]     avail;
  logic [sac_pkg::UsedW-1:0]    mem_ext;
  logic [sac_pkg::UsedW-1:0]    room_diff;
  logic [sac_pkg::UsedW-1:0]    room;
  logic [sac_pkg::UsedW-1:0]    len_ext;
  logic                         table_full;
  logic                         no_space;
  logic                         need_compact;
  logic                         base_moved;
  logic [sac_pkg::UsedW-1:0]    next_sum;
  logic [sac_pkg::UsedW-1:0]    units_add;

  sac_ram #(
    .Width($bits(sac_pkg::slot_t)),
    .Depth(sac_pkg::MaxSegments)
  ) u_sac_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Decode table position and space checks
  assign last_idx     = sac_pkg::IdxW'(count_q - sac_pkg::CntW'(1));
  assign ptr_inc      = ptr_q + sac_pkg::IdxW'(1);
  assign at_last      = (ptr_q == last_idx);
  assign shift_last   = (ptr_inc == last_idx);
  assign pos_last     = (pos_q == last_idx);
  assign key_hit      = (ram_rdata.key == item_q.segment_key);
  assign avail        = sac_pkg::units_free(units_q, memory_size_i);
  assign mem_ext      = {1'b0, memory_size_i};
  assign room_diff    = mem_ext - top_q;
  assign room         = (top_q >= mem_ext) ? '0 : room_diff;
  assign len_ext      = {1'b0, item_q.segment_length};
  assign table_full   = (count_q == sac_pkg::CntW'(sac_pkg::MaxSegments));
  assign no_space     = (item_q.segment_length > avail);
  assign need_compact = (len_ext > room);
  assign base_moved   = ({1'b0, ram_rdata.base} != next_q);
  assign next_sum     = next_q + {1'b0, ram_rdata.length};
  assign units_add    = units_q + len_ext;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sac_pkg::SIdle: begin
        if (start_i) begin
          state_d = (count_q == '0) ? sac_pkg::SDecide : sac_pkg::SScan;
        end
      end
      sac_pkg::SScan: begin
        if (at_last) begin
          state_d = sac_pkg::SDecide;
        end
      end
      sac_pkg::SDecide: begin
        if (item_q.command == sac_pkg::CmdFree) begin
          if (!found_q) begin
            state_d = sac_pkg::SIdle;
          end else if (pos_last) begin
            state_d = sac_pkg::SFreeDone;
          end else begin
            state_d = sac_pkg::SShift;
          end
        end else begin
          priority if (found_q || table_full || no_space) begin
            state_d = sac_pkg::SIdle;
          end else if (need_compact && (count_q != '0)) begin
            state_d = sac_pkg::SCompact;
          end else begin
            state_d = sac_pkg::SAppend;
          end
        end
      end
      sac_pkg::SShift: begin
        if (shift_last) begin
          state_d = sac_pkg::SFreeDone;
        end
      end
      sac_pkg::SFreeDone: begin
        state_d = sac_pkg::SIdle;
      end
      sac_pkg::SCompact: begin
        if (at_last) begin
          state_d = sac_pkg::SAppend;
        end
      end
      sac_pkg::SAppend: begin
        state_d = sac_pkg::SIdle;
      end
      default: begin
        state_d = sac_pkg::SIdle;
      end
    endcase
  end

  // Datapath, RAM access and result emission
  always_comb begin
    item_d    = item_q;
    count_d   = count_q;
    units_d   = units_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    found_d   = found_q;
    flen_d    = flen_q;
    top_d     = top_q;
    next_d    = next_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_inc;
    emit_o                   = '0;
    emit_o.res.result_key    = item_q.segment_key;
    emit_o.res.space_left    = avail;
    emit_o.res.status        = sac_pkg::StOk;
    emit_o.res.last          = 1'b1;

    unique case (state_q)
      sac_pkg::SIdle: begin
        ram_raddr = '0;
        if (start_i) begin
          item_d  = item_i;
          ptr_d   = '0;
          found_d = 1'b0;
          top_d   = '0;
        end
      end
      // Compare one row per cycle, record the hit and the table top
      sac_pkg::SScan: begin
        if (!found_q && key_hit) begin
          found_d = 1'b1;
          pos_d   = ptr_q;
          flen_d  = ram_rdata.length;
        end
        if (at_last) begin
          top_d = {1'b0, ram_rdata.base} + {1'b0, ram_rdata.length};
        end else begin
          ptr_d = ptr_inc;
        end
      end
      sac_pkg::SDecide: begin
        if (item_q.command == sac_pkg::CmdFree) begin
          ram_raddr = pos_q + sac_pkg::IdxW'(1);
          if (!found_q) begin
            emit_o.valid      = 1'b1;
            emit_o.res.status = sac_pkg::StNotFound;
          end else begin
            units_d = units_q - {1'b0, flen_q};
            ptr_d   = pos_q;
          end
        end else begin
          ram_raddr = '0;
          priority if (found_q) begin
            emit_o.valid      = 1'b1;
            emit_o.res.status = sac_pkg::StInUse;
          end else if (table_full) begin
            emit_o.valid      = 1'b1;
            emit_o.res.status = sac_pkg::StFull;
          end else if (no_space) begin
            emit_o.valid      = 1'b1;
            emit_o.res.status = sac_pkg::StNoSpace;
          end else begin
            ptr_d  = '0;
            next_d = '0;
          end
        end
      end
      // Move the row above down by one, reading two ahead
      sac_pkg::SShift: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_q + sac_pkg::IdxW'(2);
        ptr_d     = ptr_inc;
      end
      sac_pkg::SFreeDone: begin
        count_d      = count_q - sac_pkg::CntW'(1);
        emit_o.valid = 1'b1;
      end
      // Pack rows from address zero, report every row that moves
      sac_pkg::SCompact: begin
        if (base_moved) begin
          ram_we                  = 1'b1;
          ram_waddr               = ptr_q;
          ram_wdata.key           = ram_rdata.key;
          ram_wdata.base          = next_q[sac_pkg::AddrW-1:0];
          ram_wdata.length        = ram_rdata.length;
          emit_o.valid            = 1'b1;
          emit_o.res.is_relocation = 1'b1;
          emit_o.res.result_key   = ram_rdata.key;
          emit_o.res.base_address = next_q[sac_pkg::AddrW-1:0];
          emit_o.res.last         = 1'b0;
        end
        next_d = next_sum;
        if (at_last) begin
          top_d = next_sum;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      // Place the new segment on top
      sac_pkg::SAppend: begin
        ram_we                  = 1'b1;
        ram_waddr               = count_q[sac_pkg::IdxW-1:0];
        ram_wdata.key           = item_q.segment_key;
        ram_wdata.base          = top_q[sac_pkg::AddrW-1:0];
        ram_wdata.length        = item_q.segment_length;
        count_d                 = count_q + sac_pkg::CntW'(1);
        units_d                 = units_add;
        emit_o.valid            = 1'b1;
        emit_o.res.base_address = top_q[sac_pkg::AddrW-1:0];
        emit_o.res.space_left   = sac_pkg::units_free(units_add, memory_size_i);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sac_pkg::SIdle;
      count_q <= '0;
      units_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      units_q <= units_d;
      found_q <= found_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    flen_q <= flen_d;
    top_q  <= top_d;
    next_q <= next_d;
  end

  assign busy_o = (state_q != sac_pkg::SIdle);

endmodule

// ===== hw/rtl/segment_allocator_with_compaction.sv =====
// ----------------------------------------------------------------------------
// segment_allocator_with_compaction
// Keeps a segment table in address order, allocates on top, compacts when
// the room above the top segment is too small, and frees by key.
// ----------------------------------------------------------------------------
// Sequence: the key search walks the table RAM one row per cycle, and a
//   compaction walks it once more, or the close-up after a free walks the
//   rows above the freed one, through the same port.
// Throughput: one item at a time; each result shows for one cycle, in the
//   cycle after it is produced; results of one item may follow back to back.
// Reset: table empty, no space used, memory_size back to 1024.
module segment_allocator_with_compaction (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  sac_pkg::item_t            item_i,
  input  logic                      cfg_we_i,
  input  logic [sac_pkg::AddrW-1:0] cfg_wdata_i,
  output logic                      result_valid_o,
  output sac_pkg::result_t          result_o
);

  logic [sac_pkg::AddrW-1:0] memory_size_q;
  sac_pkg::emit_t            emit;
  logic                      result_valid_q;
  sac_pkg::result_t          result_q;
  logic                      engine_busy;

  // Accept an item only while the engine is idle
  sac_engine u_sac_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start && !engine_busy),
    .item_i       (item_i),
    .memory_size_i(memory_size_q),
    .busy_o       (engine_busy),
    .emit_o       (emit)
  );

  // Hold the address space size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_size_q <= sac_pkg::MemSizeReset;
    end else if (cfg_we_i) begin
      memory_size_q <= cfg_wdata_i;
    end
  end

  // Register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit.valid;
    end
  end

  // Capture the result item
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      result_q <= emit.res;
    end
  end

  assign busy           = engine_busy;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== hw/rtl/sac_checker.sv =====
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks of the segment allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input sac_pkg::result_t result_o
);

  logic final_shown;
  logic reloc_shown;
  logic bad_kind;

  // Classify the result on the ports
  assign final_shown = result_valid_o && result_o.last;
  assign reloc_shown = result_valid_o && result_o.is_relocation;
  assign bad_kind    = result_valid_o && (result_o.last == result_o.is_relocation);

  // An accepted item keeps the block busy in the next cycle
  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "no busy after accept")

  // The final result of an item shows only once the block is idle again
  `ASSERT_PROP(a_last_idle, clk_i, rst_ni, final_shown |-> !busy, "final result while busy")

  // A relocation is always followed by more results of the same item
  `ASSERT_PROP(a_reloc_busy, clk_i, rst_ni, reloc_shown |-> busy, "relocation after item end")

  // Every result is either a relocation or the final answer
  `ASSERT_NEVER(a_reloc_last, clk_i, rst_ni, bad_kind, "bad result kind")

  // Busy rises only on an accepted item
  `ASSERT_PROP(a_busy_cause, clk_i, rst_ni, $rose(busy) |-> $past(start), "busy without start")

endmodule

bind segment_allocator_with_compaction sac_checker u_sac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the segment allocator with compaction. A ledger class mirrors
// the segment table, predicts every relocation and final answer of each
// accepted item and checks the result stream field by field. Directed items
// hit the corner cases, then random allocate/free traffic runs under several
// address space sizes with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb;
  import sac_pkg::*;

  // --------------------------------------------------------------------------
  // Segment table mirror and result checker
  // --------------------------------------------------------------------------
  class segment_ledger;
    int unsigned mem_units;
    int unsigned row_key [MaxSegments];
    int unsigned row_base[MaxSegments];
    int unsigned row_len [MaxSegments];
    int unsigned rows;
    int unsigned used_units;
    result_t     pending_results[$];
    int          failures;
    int          items_seen;
    int          moves_seen;
    int          status_seen[5];

    function new();
      mem_units  = MemSizeReset;
      rows       = 0;
      used_units = 0;
      failures   = 0;
      items_seen = 0;
      moves_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned free_units();
      return (used_units >= mem_units) ? 0 : mem_units - used_units;
    endfunction

    function int find_row(int unsigned k);
      for (int i = 0; i < rows; i++) begin
        if (row_key[i] == k) return i;
      end
      return -1;
    endfunction

    // Return a random key that is in the table (live) or not, -1 if none
    function int pick_key(bit live);
      int cand[$];
      for (int k = 0; k < 16; k++) begin
        if ((find_row(k) >= 0) == live) cand = {cand, k};
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void queue_result(status_e st, bit move, int unsigned k, int unsigned b,
                               int unsigned left, bit fin);
      result_t r;
      r.status        = st;
      r.is_relocation = move;
      r.result_key    = k[KeyW-1:0];
      r.base_address  = b[AddrW-1:0];
      r.space_left    = left[LenW-1:0];
      r.last          = fin;
      pending_results = {pending_results, r};
      if (move) moves_seen++;
      else status_seen[int'(st)]++;
    endfunction

    // Apply one accepted item to the mirror and queue its results
    function void note_item(item_t it);
      int          pos;
      int unsigned k;
      int unsigned len;
      int unsigned avail;
      int unsigned top;
      int unsigned room;
      int unsigned pack_at;
      k   = it.segment_key;
      len = it.segment_length;
      pos = find_row(k);
      items_seen++;
      if (it.command == CmdFree) begin
        if (pos < 0) begin
          queue_result(StNotFound, 1'b0, k, 0, free_units(), 1'b1);
        end else begin
          used_units -= row_len[pos];
          for (int i = pos; i + 1 < rows; i++) begin
            row_key[i]  = row_key[i+1];
            row_base[i] = row_base[i+1];
            row_len[i]  = row_len[i+1];
          end
          rows--;
          queue_result(StOk, 1'b0, k, 0, free_units(), 1'b1);
        end
        return;
      end
      if (pos >= 0) begin
        queue_result(StInUse, 1'b0, k, 0, free_units(), 1'b1);
        return;
      end
      if (rows >= MaxSegments) begin
        queue_result(StFull, 1'b0, k, 0, free_units(), 1'b1);
        return;
      end
      avail = free_units();
      if (len > avail) begin
        queue_result(StNoSpace, 1'b0, k, 0, avail, 1'b1);
        return;
      end
      top = (rows > 0) ? row_base[rows-1] + row_len[rows-1] : 0;
      room = (top >= mem_units) ? 0 : mem_units - top;
      // Slide segments down when the room above the top is too small
      if (len > room) begin
        pack_at = 0;
        for (int i = 0; i < rows; i++) begin
          if (row_base[i] != pack_at) begin
            row_base[i] = pack_at;
            queue_result(StOk, 1'b1, row_key[i], pack_at, avail, 1'b0);
          end
          pack_at += row_len[i];
        end
        top = pack_at;
      end
      row_key[rows]  = k;
      row_base[rows] = top;
      row_len[rows]  = len;
      rows++;
      used_units += len;
      queue_result(StOk, 1'b0, k, top, free_units(), 1'b1);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: key %0d base %0d", got.result_key,
               got.base_address);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", int'(want.status), int'(got.status));
      check_field("is_relocation", want.is_relocation, got.is_relocation);
      check_field("result_key", want.result_key, got.result_key);
      check_field("base_address", want.base_address, got.base_address);
      check_field("space_left", want.space_left, got.space_left);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_i;
  logic             cfg_we_i;
  logic [AddrW-1:0] cfg_wdata_i;
  logic             result_valid_o;
  result_t          result_o;

  segment_ledger ledger;

  segment_allocator_with_compaction dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Check every strobed result
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) ledger.check_result(result_o);
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic item_t mk_item(cmd_e c, int unsigned len, int unsigned k);
    item_t it;
    it.command        = c;
    it.segment_length = len[LenW-1:0];
    it.segment_key    = k[KeyW-1:0];
    return it;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Present one item, optionally after a gap or a full drain, and hold it
  // until the block takes it
  task automatic send_item(item_t it, int gap, bit drain);
    if (gap > 0 || (drain && ledger.outstanding() != 0)) begin
      start <= 1'b0;
      if (drain) begin
        while (ledger.outstanding() != 0) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    ledger.note_item(it);
  endtask

  // Write the address space size once the block has gone quiet
  task automatic set_space_size(int unsigned units);
    start <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= units[AddrW-1:0];
    ledger.mem_units = units[AddrW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Length biased around the current free space
  function automatic int unsigned pick_length();
    int unsigned avail;
    avail = ledger.free_units();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(0, 65535);
      2: return (avail < 65535) ? avail + 1 : 65535;
      3: return avail;
      default: return $urandom_range(1, ledger.mem_units / 6 + 1);
    endcase
  endfunction

  // Random allocate/free traffic, mostly on keys that make the item succeed
  task automatic random_items(int count, bit no_gaps);
    item_t       it;
    int          k;
    int unsigned sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        k  = ledger.pick_key(1'b0);
        it = mk_item(CmdAlloc, pick_length(), (k < 0) ? $urandom_range(0, 15) : k);
      end else if (sel < 80) begin
        k  = ledger.pick_key(1'b1);
        it = mk_item(CmdFree, $urandom_range(0, 65535),
                     (k < 0) ? $urandom_range(0, 15) : k);
      end else if (sel < 90) begin
        it = mk_item(CmdFree, $urandom_range(0, 65535), $urandom_range(0, 15));
      end else begin
        it = mk_item(CmdAlloc, pick_length(), $urandom_range(0, 15));
      end
      send_item(it, no_gaps ? 0 : gap_len(), $urandom_range(0, 39) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sizes[7];
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    ledger      = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner cases on the reset size of 1024
    send_item(mk_item(CmdFree, 0, 5), 0, 1'b0);          // free on empty table
    send_item(mk_item(CmdAlloc, 0, 0), 0, 1'b0);         // empty segment at 0
    send_item(mk_item(CmdAlloc, 7, 0), 1, 1'b0);         // key already in use
    send_item(mk_item(CmdAlloc, 100, 1), 0, 1'b0);
    send_item(mk_item(CmdAlloc, 200, 2), 2, 1'b0);
    send_item(mk_item(CmdAlloc, 300, 3), 0, 1'b0);
    send_item(mk_item(CmdAlloc, 65535, 15), 0, 1'b0);    // no space
    send_item(mk_item(CmdFree, 65535, 2), 0, 1'b0);      // leave a hole
    send_item(mk_item(CmdAlloc, 500, 4), 3, 1'b0);       // forces compaction
    send_item(mk_item(CmdFree, 0, 15), 0, 1'b0);         // unknown key

    // Shrink the space below what is in use: free space saturates
    set_space_size(300);
    send_item(mk_item(CmdAlloc, 1, 5), 0, 1'b0);
    send_item(mk_item(CmdAlloc, 0, 6), 0, 1'b0);
    send_item(mk_item(CmdFree, 1, 4), 0, 1'b0);

    // Largest space: overflow by 400 units, then an exact fit with compaction
    set_space_size(65535);
    send_item(mk_item(CmdAlloc, 65535, 7), 0, 1'b0);
    send_item(mk_item(CmdAlloc, 65135, 7), 0, 1'b0);
    send_item(mk_item(CmdFree, 32768, 7), 0, 1'b0);

    // Random phases under several sizes, one of them without gaps
    sizes = '{1024, 1, 65535, 100, 0, 300, 1024};
    sizes[4] = $urandom_range(1, 65535);
    foreach (sizes[p]) begin
      set_space_size(sizes[p]);
      random_items(38, p == 3);
    end

    // Let the last results drain
    start <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d items through %0d space sizes, %0d compaction moves.",
             ledger.items_seen, 9, ledger.moves_seen);
    $display("Answers: ok %0d, no space %0d, not found %0d, in use %0d, full %0d.",
             ledger.status_seen[0], ledger.status_seen[1], ledger.status_seen[2],
             ledger.status_seen[3], ledger.status_seen[4]);
    if (ledger.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== segment_allocator_with_compaction.f =====
+incdir+hw/rtl
hw/rtl/sac_pkg.sv
hw/rtl/sac_ram.sv
hw/rtl/sac_engine.sv
hw/rtl/segment_allocator_with_compaction.sv
hw/rtl/sac_checker.sv
sim/tb.sv
